>>> design/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry pose update: shared types and constants
// Formats, widths and the CORDIC arctangent table of the pose update pipeline.
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int POS_BITS      = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int PHASE_BITS   = 32;
    localparam int Z_BITS       = PHASE_BITS + 1;
    localparam int XY_BITS      = 34;
    localparam int CS_BITS      = 32;
    localparam int FRAC_BITS    = 30;
    localparam int PROD_BITS    = POS_BITS + CS_BITS;
    localparam int QUO_BITS     = PROD_BITS - FRAC_BITS;
    localparam int SUM_BITS     = ((QUO_BITS > POS_BITS) ? QUO_BITS : POS_BITS) + 2;
    localparam int ATAN_ENTRIES = 24;

    typedef logic signed [POS_BITS-1:0]   pos_t;
    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [XY_BITS-1:0]    xy_t;
    typedef logic signed [Z_BITS-1:0]     z_t;
    typedef logic signed [CS_BITS-1:0]    cs_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [QUO_BITS-1:0]   quo_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    // 1/K in Q2.30
    localparam xy_t INV_GAIN = XY_BITS'(652032874);

    localparam z_t QUARTER_TURN = Z_BITS'(64'sd1 <<< (PHASE_BITS - 2));

    localparam logic [PHASE_BITS-1:0] ATAN_PHASE [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        pos_t   pos_x;
        pos_t   pos_y;
        pos_t   travel;
        angle_t heading;
        logic   flip;
    } side_t;

    typedef struct packed {
        xy_t x;
        xy_t y;
        z_t  z;
    } rot_t;

endpackage
`default_nettype wire

>>> design/odometry_pose_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry pose update
// Closed-form motion-model pose update with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while in_stall is low and returns one result beat
// per input beat, in order. A beat passes the front stage that forms the
// direction, a registered stage per CORDIC micro-rotation, and the multiply,
// round and accumulate stages. All stages advance together; while a
// result beat is held by out_stall the pipeline holds and in_stall is raised.
// ----------------------------------------------------------------------------
module odometry_pose_update
    import odo_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire pos_t   pos_x,
    input  wire pos_t   pos_y,
    input  wire angle_t heading,
    input  wire angle_t turn_first,
    input  wire pos_t   distance,
    input  wire angle_t turn_second,
    output logic        out_valid,
    input  wire logic   out_stall,
    output pos_t        next_x,
    output pos_t        next_y,
    output angle_t      next_heading,
    output logic        saturated
);

    logic  adv;
    logic  front_valid;
    z_t    front_z;
    side_t front_side;
    logic  rot_valid;
    xy_t   rot_cos;
    xy_t   rot_sin;
    side_t rot_side;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    odo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading),
        .turn_first  (turn_first),
        .distance    (distance),
        .turn_second (turn_second),
        .valid       (front_valid),
        .z           (front_z),
        .side        (front_side)
    );

    odo_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_in (front_valid),
        .z_in     (front_z),
        .side_in  (front_side),
        .valid    (rot_valid),
        .cos_x    (rot_cos),
        .sin_y    (rot_sin),
        .side     (rot_side)
    );

    odo_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .valid_in     (rot_valid),
        .cos_x        (rot_cos),
        .sin_y        (rot_sin),
        .side_in      (rot_side),
        .valid        (out_valid),
        .next_x       (next_x),
        .next_y       (next_y),
        .next_heading (next_heading),
        .saturated    (saturated)
    );

endmodule
`default_nettype wire

>>> design/odo_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry pose update: front stage
// Forms the travel direction, folds it into the right half plane and sums
// the new heading.
// ----------------------------------------------------------------------------
module odo_front
    import odo_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   adv,
    input  wire logic   in_valid,
    input  wire pos_t   pos_x,
    input  wire pos_t   pos_y,
    input  wire angle_t heading,
    input  wire angle_t turn_first,
    input  wire pos_t   distance,
    input  wire angle_t turn_second,
    output logic        valid,
    output z_t          z,
    output side_t       side
);

    logic                  valid_reg;
    z_t                    z_reg;
    z_t                    z_next;
    side_t                 side_reg;
    side_t                 side_next;
    angle_t                dir_angle;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] folded;
    logic                  flip;

    always_comb
    begin
        dir_angle = heading + turn_first;
        phase     = {dir_angle, {(PHASE_BITS - ANGLE_BITS){1'b0}}};
        // outside the quarter turns: drop half a turn
        flip      = phase[PHASE_BITS-1] ^ phase[PHASE_BITS-2];
        folded    = {phase[PHASE_BITS-1] ^ flip, phase[PHASE_BITS-2:0]};
        z_next    = $signed({folded[PHASE_BITS-1], folded});

        side_next.pos_x   = pos_x;
        side_next.pos_y   = pos_y;
        side_next.travel  = distance;
        side_next.heading = dir_angle + turn_second;
        side_next.flip    = flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            z_reg    <= z_next;
            side_reg <= side_next;
        end
    end

    assign valid = valid_reg;
    assign z     = z_reg;
    assign side  = side_reg;

    a_folded_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (z_reg >= -QUARTER_TURN) && (z_reg < QUARTER_TURN))
        else $error("folded angle outside the right half plane");

endmodule
`default_nettype wire

>>> design/odo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry pose update: CORDIC rotator
// One registered micro-rotation per stage; gives cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module odo_cordic
    import odo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire logic  valid_in,
    input  wire z_t    z_in,
    input  wire side_t side_in,
    output logic       valid,
    output xy_t        cos_x,
    output xy_t        sin_y,
    output side_t      side
);

    logic [CORDIC_STAGES-1:0] valid_reg;
    rot_t                     rot_reg  [CORDIC_STAGES];
    side_t                    side_reg [CORDIC_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[CORDIC_STAGES-2:0], valid_in};
        end
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++)
    begin : g_stage
        xy_t   px;
        xy_t   py;
        z_t    pz;
        xy_t   dx;
        xy_t   dy;
        z_t    dz;
        logic  pvalid;
        side_t pside;
        rot_t  rot_next;

        if (gi == 0)
        begin : g_first
            assign px     = INV_GAIN;
            assign py     = '0;
            assign pz     = z_in;
            assign pvalid = valid_in;
            assign pside  = side_in;
        end
        else
        begin : g_rest
            assign px     = rot_reg[gi-1].x;
            assign py     = rot_reg[gi-1].y;
            assign pz     = rot_reg[gi-1].z;
            assign pvalid = valid_reg[gi-1];
            assign pside  = side_reg[gi-1];
        end

        always_comb
        begin
            dx = py >>> gi;
            dy = px >>> gi;
            dz = Z_BITS'(ATAN_PHASE[gi]);
            if (!pz[Z_BITS-1])
            begin
                rot_next.x = px - dx;
                rot_next.y = py + dy;
                rot_next.z = pz - dz;
            end
            else
            begin
                rot_next.x = px + dx;
                rot_next.y = py - dy;
                rot_next.z = pz + dz;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv && pvalid)
            begin
                rot_reg[gi]  <= rot_next;
                side_reg[gi] <= pside;
            end
        end
    end

    assign valid = valid_reg[CORDIC_STAGES-1];
    assign cos_x = rot_reg[CORDIC_STAGES-1].x;
    assign sin_y = rot_reg[CORDIC_STAGES-1].y;
    assign side  = side_reg[CORDIC_STAGES-1];

    a_result_fits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[CORDIC_STAGES-1] |->
            ((&cos_x[XY_BITS-1:CS_BITS-1]) || !(|cos_x[XY_BITS-1:CS_BITS-1])) &&
            ((&sin_y[XY_BITS-1:CS_BITS-1]) || !(|sin_y[XY_BITS-1:CS_BITS-1])))
        else $error("CORDIC result exceeds multiplier operand width");

endmodule
`default_nettype wire

>>> design/odo_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry pose update: scale and accumulate
// Multiplies distance by cosine and sine, rounds, adds to the pose (negated for a folded direction) and clips.
// ----------------------------------------------------------------------------
module odo_scale
    import odo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire logic  valid_in,
    input  wire xy_t   cos_x,
    input  wire xy_t   sin_y,
    input  wire side_t side_in,
    output logic       valid,
    output pos_t       next_x,
    output pos_t       next_y,
    output angle_t     next_heading,
    output logic       saturated
);

    localparam prod_t RND_BIAS = PROD_BITS'((64'sd1 <<< (FRAC_BITS - 1)) - 64'sd1);
    localparam sum_t  POS_MAX  = (SUM_BITS'(1) <<< (POS_BITS - 1)) - SUM_BITS'(1);
    localparam sum_t  POS_MIN  = -POS_MAX - SUM_BITS'(1);

    logic [2:0] valid_reg;

    // multiply
    cs_t    cs_x;
    cs_t    cs_y;
    prod_t  prod_x_next;
    prod_t  prod_y_next;
    prod_t  prod_x_reg;
    prod_t  prod_y_reg;
    pos_t   pos_x_m_reg;
    pos_t   pos_y_m_reg;
    angle_t heading_m_reg;
    logic   flip_m_reg;

    // round
    prod_t  rnd_x;
    prod_t  rnd_y;
    quo_t   quo_x_reg;
    quo_t   quo_y_reg;
    pos_t   pos_x_r_reg;
    pos_t   pos_y_r_reg;
    angle_t heading_r_reg;
    logic   flip_r_reg;

    // accumulate and clip
    sum_t   mask;
    sum_t   carry;
    sum_t   sum_x;
    sum_t   sum_y;
    pos_t   next_x_next;
    pos_t   next_y_next;
    logic   clip_x;
    logic   clip_y;
    pos_t   next_x_reg;
    pos_t   next_y_reg;
    angle_t next_heading_reg;
    logic   saturated_reg;

    assign cs_x        = $signed(cos_x[CS_BITS-1:0]);
    assign cs_y        = $signed(sin_y[CS_BITS-1:0]);
    assign prod_x_next = side_in.travel * cs_x;
    assign prod_y_next = side_in.travel * cs_y;

    // round to nearest, ties away from zero
    assign rnd_x = prod_x_reg + RND_BIAS + $signed({{(PROD_BITS-1){1'b0}}, ~prod_x_reg[PROD_BITS-1]});
    assign rnd_y = prod_y_reg + RND_BIAS + $signed({{(PROD_BITS-1){1'b0}}, ~prod_y_reg[PROD_BITS-1]});

    // negate for the folded half plane through the carry-in
    always_comb
    begin
        mask  = {SUM_BITS{flip_r_reg}};
        carry = $signed({{(SUM_BITS-1){1'b0}}, flip_r_reg});
        sum_x = SUM_BITS'(pos_x_r_reg) + (SUM_BITS'(quo_x_reg) ^ mask) + carry;
        sum_y = SUM_BITS'(pos_y_r_reg) + (SUM_BITS'(quo_y_reg) ^ mask) + carry;

        clip_x = 1'b1;
        if (sum_x > POS_MAX)
        begin
            next_x_next = POS_MAX[POS_BITS-1:0];
        end
        else if (sum_x < POS_MIN)
        begin
            next_x_next = POS_MIN[POS_BITS-1:0];
        end
        else
        begin
            next_x_next = sum_x[POS_BITS-1:0];
            clip_x      = 1'b0;
        end

        clip_y = 1'b1;
        if (sum_y > POS_MAX)
        begin
            next_y_next = POS_MAX[POS_BITS-1:0];
        end
        else if (sum_y < POS_MIN)
        begin
            next_y_next = POS_MIN[POS_BITS-1:0];
        end
        else
        begin
            next_y_next = sum_y[POS_BITS-1:0];
            clip_y      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_in)
        begin
            prod_x_reg    <= prod_x_next;
            prod_y_reg    <= prod_y_next;
            pos_x_m_reg   <= side_in.pos_x;
            pos_y_m_reg   <= side_in.pos_y;
            heading_m_reg <= side_in.heading;
            flip_m_reg    <= side_in.flip;
        end
        if (adv && valid_reg[0])
        begin
            quo_x_reg     <= rnd_x[PROD_BITS-1:FRAC_BITS];
            quo_y_reg     <= rnd_y[PROD_BITS-1:FRAC_BITS];
            pos_x_r_reg   <= pos_x_m_reg;
            pos_y_r_reg   <= pos_y_m_reg;
            heading_r_reg <= heading_m_reg;
            flip_r_reg    <= flip_m_reg;
        end
        if (adv && valid_reg[1])
        begin
            next_x_reg       <= next_x_next;
            next_y_reg       <= next_y_next;
            next_heading_reg <= heading_r_reg;
            saturated_reg    <= clip_x | clip_y;
        end
    end

    assign valid        = valid_reg[2];
    assign next_x       = next_x_reg;
    assign next_y       = next_y_reg;
    assign next_heading = next_heading_reg;
    assign saturated    = saturated_reg;

    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && saturated_reg) |->
            (next_x_reg == POS_MAX[POS_BITS-1:0]) || (next_x_reg == POS_MIN[POS_BITS-1:0]) ||
            (next_y_reg == POS_MAX[POS_BITS-1:0]) || (next_y_reg == POS_MIN[POS_BITS-1:0]))
        else $error("saturation flagged without a clipped coordinate");

endmodule
`default_nettype wire
